>>> hdl/qvr_pkg.sv
// Package for the quaternion vector rotation block.
// Holds the fixed-point format constants and the derived datapath widths.
// No dependencies.
package qvr_pkg;

  // Input formats
  localparam int QUAT_BITS      = 16;
  localparam int QUAT_FRAC_BITS = 14;
  localparam int VEC_BITS       = 16;
  localparam int OUT_W          = VEC_BITS + 1;

  // Datapath widths
  localparam int PROD_W = 2 * QUAT_BITS;          // component product
  localparam int MAT_W  = PROD_W + 2;             // matrix entry, scale 2^(2F)
  localparam int MV_W   = MAT_W + VEC_BITS;       // entry times vector component
  localparam int SUM_W  = MV_W + 2;               // three-term sum plus rounding
  localparam int SHIFT  = 2 * QUAT_FRAC_BITS;
  localparam int ACC_A  = (SUM_W > SHIFT + 1) ? SUM_W : SHIFT + 1;
  localparam int ACC_W  = (ACC_A > OUT_W + 1) ? ACC_A : OUT_W + 1;

  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) <<< (SHIFT - 1);
  localparam logic signed [ACC_W-1:0] SAT_HI   = (ACC_W'(1) <<< VEC_BITS) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] SAT_LO   = -(ACC_W'(1) <<< VEC_BITS);

  localparam int NUM_STAGES = 5;

endpackage

>>> hdl/quaternion_vector_rotate_top.sv
// Quaternion vector rotation, top level: rot = vector part of q * (0,v) * conj(q).
// Five-stage pipeline, matrix form, one rounding and a saturating clamp at the end.
// Depends on qvr_pkg.
//
//   channel | direction | handshake            | payload
//   in_     | request   | in_valid / in_stall  | quat_w/x/y/z (Q1.14), vec_x/y/z
//   out_    | result    | out_valid / out_stall| rot_x/y/z (17b), saturated
//
// One item per cycle sustained while out_stall stays low; an accepted item passes
// through the stage registers in order, and out_valid rises when it reaches the output register.
// Stages: quaternion products, matrix entries, entry*vector multiplies,
// row sums with rounding, shift and clamp into the output register.
// Each stage holds its item only while the stage after it is full and holding,
// so empty stages keep filling while a result waits at the output.
// rst_n (synchronous) clears the stage valid bits; data registers are not reset.

module quaternion_vector_rotate_top
  import qvr_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,

  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [QUAT_BITS-1:0] in_quat_w,
  input  logic signed [QUAT_BITS-1:0] in_quat_x,
  input  logic signed [QUAT_BITS-1:0] in_quat_y,
  input  logic signed [QUAT_BITS-1:0] in_quat_z,
  input  logic signed [VEC_BITS-1:0]  in_vec_x,
  input  logic signed [VEC_BITS-1:0]  in_vec_y,
  input  logic signed [VEC_BITS-1:0]  in_vec_z,

  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [OUT_W-1:0]     out_rot_x,
  output logic signed [OUT_W-1:0]     out_rot_y,
  output logic signed [OUT_W-1:0]     out_rot_z,
  output logic                        out_saturated
);

  logic [NUM_STAGES:1] vld_r;
  logic [NUM_STAGES:1] adv;

  // stage 1: component products
  logic signed [PROD_W-1:0] p_ww_r, p_xx_r, p_yy_r, p_zz_r;
  logic signed [PROD_W-1:0] p_xy_r, p_wz_r, p_xz_r, p_wy_r, p_yz_r, p_wx_r;
  logic signed [VEC_BITS-1:0] v1_r [3];
  // stage 2: rotation matrix
  logic signed [MAT_W-1:0]    mat_r [3][3];
  logic signed [VEC_BITS-1:0] v2_r [3];
  // stage 3: partial products
  logic signed [MV_W-1:0]     mv_r [3][3];
  // stage 4: rounded row sums
  logic signed [ACC_W-1:0]    acc_r [3];
  // stage 5: output
  logic signed [OUT_W-1:0]    rot_r [3];
  logic                       sat_r;

  logic signed [ACC_W-1:0]    shr   [3];
  logic signed [OUT_W-1:0]    rot_nxt [3];
  logic [2:0]                 clip;

  // stall ripples back only through full stages
  always_comb begin
    adv[NUM_STAGES] = !vld_r[NUM_STAGES] || !out_stall;
    for (int k = NUM_STAGES - 1; k >= 1; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
  end

  assign in_stall = !adv[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[1]) vld_r[1] <= in_valid;
      for (int k = 2; k <= NUM_STAGES; k++) begin
        if (adv[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      p_ww_r <= PROD_W'(in_quat_w * in_quat_w);
      p_xx_r <= PROD_W'(in_quat_x * in_quat_x);
      p_yy_r <= PROD_W'(in_quat_y * in_quat_y);
      p_zz_r <= PROD_W'(in_quat_z * in_quat_z);
      p_xy_r <= PROD_W'(in_quat_x * in_quat_y);
      p_wz_r <= PROD_W'(in_quat_w * in_quat_z);
      p_xz_r <= PROD_W'(in_quat_x * in_quat_z);
      p_wy_r <= PROD_W'(in_quat_w * in_quat_y);
      p_yz_r <= PROD_W'(in_quat_y * in_quat_z);
      p_wx_r <= PROD_W'(in_quat_w * in_quat_x);
      v1_r[0] <= in_vec_x;
      v1_r[1] <= in_vec_y;
      v1_r[2] <= in_vec_z;
    end
  end

  // products are sign-extended before the add, so -2.0 codes stay exact
  always_ff @(posedge clk) begin
    if (adv[2]) begin
      mat_r[0][0] <= MAT_W'(p_ww_r) + MAT_W'(p_xx_r) - MAT_W'(p_yy_r) - MAT_W'(p_zz_r);
      mat_r[1][1] <= MAT_W'(p_ww_r) - MAT_W'(p_xx_r) + MAT_W'(p_yy_r) - MAT_W'(p_zz_r);
      mat_r[2][2] <= MAT_W'(p_ww_r) - MAT_W'(p_xx_r) - MAT_W'(p_yy_r) + MAT_W'(p_zz_r);
      mat_r[0][1] <= (MAT_W'(p_xy_r) - MAT_W'(p_wz_r)) <<< 1;
      mat_r[0][2] <= (MAT_W'(p_xz_r) + MAT_W'(p_wy_r)) <<< 1;
      mat_r[1][0] <= (MAT_W'(p_xy_r) + MAT_W'(p_wz_r)) <<< 1;
      mat_r[1][2] <= (MAT_W'(p_yz_r) - MAT_W'(p_wx_r)) <<< 1;
      mat_r[2][0] <= (MAT_W'(p_xz_r) - MAT_W'(p_wy_r)) <<< 1;
      mat_r[2][1] <= (MAT_W'(p_yz_r) + MAT_W'(p_wx_r)) <<< 1;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          mv_r[i][j] <= MV_W'(mat_r[i][j]) * MV_W'(v2_r[j]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      for (int i = 0; i < 3; i++) begin
        acc_r[i] <= ACC_W'(mv_r[i][0]) + ACC_W'(mv_r[i][1]) + ACC_W'(mv_r[i][2])
                    + RND_HALF;
      end
    end
  end

  // arithmetic shift gives the floor; then clamp to the output range
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      shr[i] = acc_r[i] >>> SHIFT;
      if (shr[i] > SAT_HI) begin
        rot_nxt[i] = SAT_HI[OUT_W-1:0];
        clip[i]    = 1'b1;
      end else if (shr[i] < SAT_LO) begin
        rot_nxt[i] = SAT_LO[OUT_W-1:0];
        clip[i]    = 1'b1;
      end else begin
        rot_nxt[i] = shr[i][OUT_W-1:0];
        clip[i]    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      rot_r <= rot_nxt;
      sat_r <= |clip;
    end
  end

  assign out_valid     = vld_r[NUM_STAGES];
  assign out_rot_x     = rot_r[0];
  assign out_rot_y     = rot_r[1];
  assign out_rot_z     = rot_r[2];
  assign out_saturated = sat_r;

`ifndef ASSERT_OFF
  // a flagged result has at least one component sitting on a bound
  a_sat_on_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |->
      out_rot_x == SAT_HI[OUT_W-1:0] || out_rot_x == SAT_LO[OUT_W-1:0] ||
      out_rot_y == SAT_HI[OUT_W-1:0] || out_rot_y == SAT_LO[OUT_W-1:0] ||
      out_rot_z == SAT_HI[OUT_W-1:0] || out_rot_z == SAT_LO[OUT_W-1:0])
    else $error("saturated flag without a clamped component");

  // input back-pressure only when every stage is full and the output holds
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (&vld_r) && out_stall)
    else $error("input stalled with a free pipeline slot");

  // a held item in the middle of the pipe is not dropped
  a_hold_mid: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[3] && !adv[3] |=> vld_r[3])
    else $error("stage 3 item lost while held");

  a_hold_pre: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[4] && !adv[4] |=> vld_r[4] && $stable(acc_r[0]))
    else $error("stage 4 item changed while held");
`endif

endmodule

>>> tb/tb.sv
// Self-checking testbench for quaternion_vector_rotate_top: directed corners, then random
// quaternion/vector requests under random sender bursts and receiver stalls.
// Depends on qvr_pkg and the block's RTL.
module tb
  import qvr_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_REQUESTS = 1950;
  localparam int CYCLE_LIMIT     = 400000;

  typedef struct {
    logic signed [QUAT_BITS-1:0] qw, qx, qy, qz;
    logic signed [VEC_BITS-1:0]  vx, vy, vz;
  } rotate_req_t;

  typedef struct {
    logic signed [OUT_W-1:0] x, y, z;
    logic                    sat;
  } rotate_res_t;

  class rotation_scoreboard;
    rotate_res_t expected_rotations[$];
    int n_mismatch;
    int n_requests;
    int n_results;
    int n_saturated;

    // Matrix form of q*(0,v)*conj(q) at scale 2^(2F), exact in 64 bits, one rounding.
    function rotate_res_t rotate_vector(rotate_req_t r);
      longint w, x, y, z;
      longint m[3][3];
      longint v[3];
      longint acc;
      longint top, bot;
      longint comp[3];
      rotate_res_t res;
      w = r.qw; x = r.qx; y = r.qy; z = r.qz;
      v[0] = r.vx; v[1] = r.vy; v[2] = r.vz;
      top = (64'sd1 <<< VEC_BITS) - 1;
      bot = -top - 1;
      m[0][0] = w*w + x*x - y*y - z*z;
      m[0][1] = 2 * (x*y - w*z);
      m[0][2] = 2 * (x*z + w*y);
      m[1][0] = 2 * (x*y + w*z);
      m[1][1] = w*w - x*x + y*y - z*z;
      m[1][2] = 2 * (y*z - w*x);
      m[2][0] = 2 * (x*z - w*y);
      m[2][1] = 2 * (y*z + w*x);
      m[2][2] = w*w - x*x - y*y + z*z;
      res.sat = 1'b0;
      for (int i = 0; i < 3; i++) begin
        acc = m[i][0]*v[0] + m[i][1]*v[1] + m[i][2]*v[2] + (64'sd1 <<< (SHIFT - 1));
        acc = acc >>> SHIFT;  // floor: round half up
        if (acc > top) begin
          acc = top;
          res.sat = 1'b1;
        end else if (acc < bot) begin
          acc = bot;
          res.sat = 1'b1;
        end
        comp[i] = acc;
      end
      res.x = OUT_W'(comp[0]);
      res.y = OUT_W'(comp[1]);
      res.z = OUT_W'(comp[2]);
      return res;
    endfunction

    function void note_request(rotate_req_t r);
      n_requests++;
      expected_rotations.insert(expected_rotations.size(), rotate_vector(r));
    endfunction

    function int pending();
      return expected_rotations.size();
    endfunction

    task report_mismatch(string msg);
      n_mismatch++;
      $display("MISMATCH result %0d: %s", n_results, msg);
    endtask

    task check_result(rotate_res_t got);
      rotate_res_t want;
      n_results++;
      if (got.sat === 1'b1) n_saturated++;
      if (expected_rotations.size() == 0) begin
        report_mismatch("result with no request outstanding");
        return;
      end
      want = expected_rotations.pop_front();
      if (got.x !== want.x)
        report_mismatch($sformatf("rot_x got %0d want %0d", got.x, want.x));
      if (got.y !== want.y)
        report_mismatch($sformatf("rot_y got %0d want %0d", got.y, want.y));
      if (got.z !== want.z)
        report_mismatch($sformatf("rot_z got %0d want %0d", got.z, want.z));
      if (got.sat !== want.sat)
        report_mismatch($sformatf("saturated got %0b want %0b", got.sat, want.sat));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [QUAT_BITS-1:0] in_quat_w = '0, in_quat_x = '0, in_quat_y = '0, in_quat_z = '0;
  logic signed [VEC_BITS-1:0]  in_vec_x = '0, in_vec_y = '0, in_vec_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [OUT_W-1:0] out_rot_x, out_rot_y, out_rot_z;
  logic out_saturated;

  rotation_scoreboard sb = new();
  rotate_req_t directed[$];
  int cycle_count = 0;
  int held_off_cycles = 0;

  quaternion_vector_rotate_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_quat_w(in_quat_w), .in_quat_x(in_quat_x),
    .in_quat_y(in_quat_y), .in_quat_z(in_quat_z),
    .in_vec_x(in_vec_x), .in_vec_y(in_vec_y), .in_vec_z(in_vec_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_rot_x(out_rot_x), .out_rot_y(out_rot_y), .out_rot_z(out_rot_z),
    .out_saturated(out_saturated)
  );

  always #2 clk = ~clk;

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) begin
    rotate_req_t r;
    rotate_res_t res;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, sb.pending());
      $display("tb NOT OK");
      $finish;
    end else if (rst_n) begin
      if (in_valid && in_stall === 1'b0) begin
        r.qw = in_quat_w; r.qx = in_quat_x; r.qy = in_quat_y; r.qz = in_quat_z;
        r.vx = in_vec_x;  r.vy = in_vec_y;  r.vz = in_vec_z;
        sb.note_request(r);
      end else if (in_valid) begin
        held_off_cycles++;
      end
      if (out_valid === 1'b1 && !out_stall) begin
        res.x = out_rot_x; res.y = out_rot_y; res.z = out_rot_z; res.sat = out_saturated;
        sb.check_result(res);
      end
    end
  end

  function automatic void push_case(int w, int x, int y, int z, int vx, int vy, int vz);
    rotate_req_t r;
    r.qw = QUAT_BITS'(w); r.qx = QUAT_BITS'(x); r.qy = QUAT_BITS'(y); r.qz = QUAT_BITS'(z);
    r.vx = VEC_BITS'(vx); r.vy = VEC_BITS'(vy); r.vz = VEC_BITS'(vz);
    directed.insert(directed.size(), r);
  endfunction

  function automatic logic signed [QUAT_BITS-1:0] pick_quat_corner();
    int corners[7] = '{-32768, -16384, -1, 0, 1, 16384, 32767};
    return QUAT_BITS'(corners[$urandom_range(0, 6)]);
  endfunction

  function automatic logic signed [VEC_BITS-1:0] pick_vec();
    int corners[4] = '{-32768, -1, 0, 32767};
    case ($urandom_range(0, 3))
      0: return VEC_BITS'(int'($urandom_range(0, 200)) - 100);
      1: return VEC_BITS'(corners[$urandom_range(0, 3)]);
      default: return VEC_BITS'($urandom);
    endcase
  endfunction

  function automatic rotate_req_t make_random_request();
    rotate_req_t r;
    real a, b, c, d, n, scale;
    int kind;
    kind = $urandom_range(0, 9);
    if (kind <= 5) begin
      // unit quaternion mostly, otherwise a random magnitude below 2.0
      a = real'(int'($urandom_range(0, 65535)) - 32768);
      b = real'(int'($urandom_range(0, 65535)) - 32768);
      c = real'(int'($urandom_range(0, 65535)) - 32768);
      d = real'(int'($urandom_range(0, 65535)) - 32768);
      n = $sqrt(a*a + b*b + c*c + d*d);
      if (n < 1.0) n = 1.0;
      scale = (kind <= 3) ? 16384.0 : real'($urandom_range(1, 32767));
      r.qw = QUAT_BITS'($rtoi(a * scale / n));
      r.qx = QUAT_BITS'($rtoi(b * scale / n));
      r.qy = QUAT_BITS'($rtoi(c * scale / n));
      r.qz = QUAT_BITS'($rtoi(d * scale / n));
    end else if (kind <= 7) begin
      r.qw = QUAT_BITS'($urandom); r.qx = QUAT_BITS'($urandom);
      r.qy = QUAT_BITS'($urandom); r.qz = QUAT_BITS'($urandom);
    end else if (kind == 8) begin
      r.qw = pick_quat_corner(); r.qx = pick_quat_corner();
      r.qy = pick_quat_corner(); r.qz = pick_quat_corner();
    end else begin
      r.qw = QUAT_BITS'(int'($urandom_range(0, 64)) - 32);
      r.qx = QUAT_BITS'(int'($urandom_range(0, 64)) - 32);
      r.qy = QUAT_BITS'(int'($urandom_range(0, 64)) - 32);
      r.qz = QUAT_BITS'(int'($urandom_range(0, 64)) - 32);
    end
    r.vx = pick_vec(); r.vy = pick_vec(); r.vz = pick_vec();
    return r;
  endfunction

  task automatic send_request(input rotate_req_t r);
    in_valid  <= 1'b1;
    in_quat_w <= r.qw; in_quat_x <= r.qx; in_quat_y <= r.qy; in_quat_z <= r.qz;
    in_vec_x  <= r.vx; in_vec_y  <= r.vy; in_vec_z  <= r.vz;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
  endtask

  // receiver: stall patterns in random spans, with periodic long hold-offs
  initial begin : receiver
    int mode, span, k, round;
    round = 0;
    wait (rst_n);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 200);
      for (k = 0; k < span; k++) begin
        @(posedge clk);
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 99) < 30);
          2: out_stall <= ($urandom_range(0, 99) < 70);
          default: out_stall <= k[0];
        endcase
      end
      round++;
      if (round % 12 == 5) begin
        // long hold-off so the pipeline fills and pushes back on the sender
        @(posedge clk);
        out_stall <= 1'b1;
        repeat (80) @(posedge clk);
      end
    end
  end

  initial begin : sender
    rotate_req_t r;
    int burst_left, gap, total, i;
    push_case(16384, 0, 0, 0, 32767, -32768, 1);           // identity
    push_case(16384, 0, 0, 0, -1, 0, -32768);
    push_case(-16384, 0, 0, 0, -32768, -32768, -32768);    // negated identity
    push_case(-32768, -32768, -32768, -32768, 32767, 32767, 32767);
    push_case(-32768, -32768, -32768, -32768, -32768, -32768, -32768);
    push_case(32767, 32767, 32767, 32767, 32767, -32768, 32767);
    push_case(0, 0, 0, 0, 12345, -1, 32767);                // zero quaternion
    push_case(11585, 0, 0, 11585, 1000, 0, 0);              // 90 deg about z
    push_case(0, 16384, 0, 0, 100, 200, 300);               // 180 deg about x
    push_case(0, 0, 16384, 0, 1, 2, 3);
    push_case(8192, 0, 0, 0, 2, -2, -6);                    // exact half-LSB ties
    push_case(8192, 0, 0, 0, 3, -3, 1);
    push_case(0, -32768, 0, 0, 32767, 32767, -32768);       // |q|^2 = 4, clamps
    push_case(32767, 0, 0, 0, -32768, 32767, 0);
    push_case(0, 0, 0, -32768, 32767, 32767, -32768);
    push_case(23170, 0, 0, 0, 32767, -32768, 0);            // |q|^2 near 2
    push_case(1, 1, 1, 1, 32767, 32767, 32767);             // tiny quaternion
    push_case(16384, 16384, 16384, 16384, 1234, -4321, 777);
    burst_left = 0;
    wait (rst_n);
    @(posedge clk);
    total = directed.size() + RANDOM_REQUESTS;
    for (i = 0; i < total; i++) begin
      if (i < directed.size()) r = directed[i];
      else r = make_random_request();
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 48);
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;
      send_request(r);
    end
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4 * NUM_STAGES) @(posedge clk);
    $display("ran %0d rotation requests (%0d directed corners), %0d results, %0d saturated",
             sb.n_requests, directed.size(), sb.n_results, sb.n_saturated);
    $display("input held off for %0d cycles; %0d field mismatches",
             held_off_cycles, sb.n_mismatch);
    if (sb.n_mismatch == 0 && sb.pending() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
